// ===== sv/atan2_pkg.sv =====
// shared constants, types and helpers for the atan2 polynomial angle block
package atan2_pkg;

  // ratio and coefficient format
  localparam int unsigned QBITS = 24;
  localparam int unsigned RW    = QBITS + 1;
  localparam int unsigned ACCW  = 26;
  localparam int unsigned ANGLE_W = 32;

  // polynomial coefficients, Q24
  localparam logic signed [ACCW-1:0] C0 = 26'sd16774968;
  localparam logic signed [ACCW-1:0] C1 = -26'sd5541506;
  localparam logic signed [ACCW-1:0] C2 = 26'sd3022264;
  localparam logic signed [ACCW-1:0] C3 = -26'sd1428295;
  localparam logic signed [ACCW-1:0] C4 = 26'sd349555;

  // pi in Q32
  localparam logic [35:0] PI_Q32 = 36'd13493037705;

  // quadrant flags that travel with an item
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic y_neg;
    logic x_neg;
    logic swap;
  } quad_t;

  // Q24 product, round half up via floor shift
  function automatic logic signed [ACCW-1:0] mul_q24(
    input logic signed [ACCW-1:0] a,
    input logic signed [ACCW-1:0] b
  );
    logic signed [2*ACCW-1:0] p;
    p = (a * b) + (52'sd1 <<< 23);
    return ACCW'(p >>> 24);
  endfunction

endpackage

// ===== sv/atan2_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module atan2_div #(
  parameter int NW = 24,
  parameter int QW = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [NW-1:0]         num,
  input  logic [NW-1:0]         den,
  input  atan2_pkg::quad_t      in_quad,
  output logic                  out_valid,
  output logic [QW-1:0]         quot,
  output atan2_pkg::quad_t      out_quad
);

  logic [NW:0]   rem_r  [QW+1];
  logic [NW-1:0] den_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic          v_r    [QW+1];
  atan2_pkg::quad_t quad_r [QW+1];

  // entry stage: numerator is below or equal to divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {1'b0, num};
      den_r[0]  <= den;
      q_r[0]    <= '0;
      quad_r[0] <= in_quad;
    end
  end

  // one quotient bit per stage, msb first; the first stage yields the integer bit
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW+1:0] sh;
    logic [NW+1:0] diff;
    logic          ge;
    if (s == 0) begin : g_int
      assign sh = {1'b0, rem_r[s]};
    end else begin : g_frac
      assign sh = {rem_r[s], 1'b0};
    end
    assign diff = sh - {2'b00, den_r[s]};
    assign ge   = !diff[NW+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? diff[NW:0] : sh[NW:0];
        q_r[s+1]    <= {q_r[s][QW-2:0], ge};
        den_r[s+1]  <= den_r[s];
        quad_r[s+1] <= quad_r[s];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign quot      = q_r[QW];
  assign out_quad  = quad_r[QW];

endmodule

// ===== sv/atan2_poly.sv =====
// pipelined horner evaluation of the odd atan polynomial
module atan2_poly (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [atan2_pkg::RW-1:0] ratio,
  input  atan2_pkg::quad_t      in_quad,
  output logic                  out_valid,
  output logic [atan2_pkg::ACCW-1:0] poly,
  output atan2_pkg::quad_t      out_quad
);

  localparam int NS = 6;
  localparam int AW = atan2_pkg::ACCW;

  logic          v_r    [NS+1];
  logic signed [AW-1:0] r_r   [NS+1];
  logic signed [AW-1:0] t_r   [NS+1];
  logic signed [AW-1:0] acc_r [NS+1];
  atan2_pkg::quad_t quad_r [NS+1];
  logic signed [AW-1:0] acc_nxt [NS];

  // stage inputs
  always_comb begin
    acc_nxt[0] = atan2_pkg::C4;
    acc_nxt[1] = atan2_pkg::C3 + atan2_pkg::mul_q24(acc_r[1], t_r[1]);
    acc_nxt[2] = atan2_pkg::C2 + atan2_pkg::mul_q24(acc_r[2], t_r[2]);
    acc_nxt[3] = atan2_pkg::C1 + atan2_pkg::mul_q24(acc_r[3], t_r[3]);
    acc_nxt[4] = atan2_pkg::C0 + atan2_pkg::mul_q24(acc_r[4], t_r[4]);
    acc_nxt[5] = atan2_pkg::mul_q24(r_r[5], acc_r[5]);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= NS; i++) v_r[i] <= v_r[i-1];
    end
  end

  // payload: stage 0 squares, later stages run horner steps
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= AW'(ratio);
      quad_r[0] <= in_quad;
      t_r[0]    <= '0;
      acc_r[0]  <= '0;
      r_r[1]    <= r_r[0];
      quad_r[1] <= quad_r[0];
      t_r[1]    <= atan2_pkg::mul_q24(r_r[0], r_r[0]);
      acc_r[1]  <= acc_nxt[0];
      for (int i = 2; i <= NS; i++) begin
        r_r[i]    <= r_r[i-1];
        quad_r[i] <= quad_r[i-1];
        t_r[i]    <= t_r[i-1];
        acc_r[i]  <= acc_nxt[i-1];
      end
    end
  end

  // clamp negatives to zero
  assign out_valid = v_r[NS];
  assign poly      = acc_r[NS][AW-1] ? '0 : acc_r[NS];
  assign out_quad  = quad_r[NS];

endmodule

// ===== sv/atan2_polynomial_angle.sv =====
// top level: four-quadrant fixed-point arctangent
// a result travels from the accepting edge through the input register,
// 27 divider registers, 7 polynomial registers and the output register
// throughput: one beat per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// a stalled output holds the whole pipeline; the input is ready whenever
// the output register is empty or being taken
// reset clears all valid bits; payload registers are not reset
module atan2_polynomial_angle #(
  parameter int INPUT_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 29
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*INPUT_WIDTH+((8-(2*INPUT_WIDTH)%8)%8)-1:0] in_tdata, // coord_y, coord_x
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata  // angle
);

  localparam int W    = INPUT_WIDTH;
  localparam int QW   = atan2_pkg::QBITS + 2;
  localparam int AW   = atan2_pkg::ACCW;
  localparam int OW   = atan2_pkg::ANGLE_W;
  localparam int HSH  = 33 - ANGLE_FRAC_BITS;
  localparam int FSH  = 32 - ANGLE_FRAC_BITS;
  localparam logic [35:0] PI_F = (atan2_pkg::PI_Q32 + (36'd1 << (FSH-1))) >> FSH;
  localparam logic [35:0] PI_H = (atan2_pkg::PI_Q32 + (36'd1 << (HSH-1))) >> HSH;
  localparam logic signed [OW-1:0] PI_O  = OW'(PI_F);
  localparam logic signed [OW-1:0] PIH_O = OW'(PI_H);

  logic en;
  logic signed [W-1:0] y_in, x_in;
  logic [W-1:0] ay, ax;
  atan2_pkg::quad_t q_in;

  // magnitudes and quadrant
  assign y_in = in_tdata[W-1:0];
  assign x_in = in_tdata[2*W-1:W];
  assign ay = y_in[W-1] ? W'(-y_in) : W'(y_in);
  assign ax = x_in[W-1] ? W'(-x_in) : W'(x_in);
  always_comb begin
    q_in.x_zero = (x_in == '0);
    q_in.y_zero = (y_in == '0);
    q_in.y_neg  = y_in[W-1];
    q_in.x_neg  = x_in[W-1];
    q_in.swap   = ay > ax;
  end

  logic          in_v_r;
  logic [W-1:0]  num_r, den_r;
  atan2_pkg::quad_t q_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= q_in.swap ? ax : ay;
      den_r <= q_in.swap ? ay : ax;
      q_r   <= q_in;
    end
  end

  logic div_v;
  logic [QW-1:0] quot;
  atan2_pkg::quad_t div_q;

  // a zero divisor only occurs with x zero, which is overridden later
  atan2_div #(.NW(W), .QW(QW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_v_r),
    .num(num_r), .den(den_r), .in_quad(q_r),
    .out_valid(div_v), .quot(quot), .out_quad(div_q)
  );

  logic [atan2_pkg::RW-1:0] ratio;
  assign ratio = atan2_pkg::RW'((QW'(quot) + QW'(1)) >> 1);

  logic poly_v;
  logic [AW-1:0] poly;
  atan2_pkg::quad_t poly_q;

  atan2_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(div_v),
    .ratio(ratio), .in_quad(div_q),
    .out_valid(poly_v), .poly(poly), .out_quad(poly_q)
  );

  // scale and fold into the quadrant
  logic [OW-1:0] mag;
  logic signed [OW-1:0] a0, a1, a2, res;
  always_comb begin
    if (ANGLE_FRAC_BITS >= 24) begin
      mag = OW'(poly) << (ANGLE_FRAC_BITS - 24);
    end else begin
      mag = (OW'(poly) + (OW'(1) << (23 - ANGLE_FRAC_BITS))) >> (24 - ANGLE_FRAC_BITS);
    end
    a0 = poly_q.swap ? (PIH_O - $signed(mag)) : $signed(mag);
    a1 = (poly_q.y_neg != poly_q.x_neg) ? -a0 : a0;
    a2 = !poly_q.x_neg ? a1 : (poly_q.y_neg ? a1 - PI_O : a1 + PI_O);
    if (poly_q.x_zero) begin
      res = poly_q.y_zero ? '0 : (poly_q.y_neg ? -PIH_O : PIH_O);
    end else begin
      res = a2;
    end
  end

  logic out_v_r;
  logic [OW-1:0] out_d_r;

  // output register; pipeline advances when it can move
  assign en = !out_v_r || out_tready;
  assign in_tready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= poly_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= res;
    end
  end
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // ratio never exceeds one
  a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    div_v && !div_q.x_zero |-> ratio <= (atan2_pkg::RW'(1) << atan2_pkg::QBITS))
    else $error("ratio above one");
  // result range within pi
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    poly_v |-> (res <= PI_O) && (res >= -PI_O))
    else $error("angle out of range");
  // stall freezes pipeline valid
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(poly_v))
    else $error("pipeline moved during stall");

endmodule
